[hdl/b32d_pkg.sv]
// shared types, constants and the character classifier for the base32 decoder
package b32d_pkg;

    localparam int CHAR_W      = 8;
    localparam int SYM_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int POS_W       = 3;
    localparam int MAX_BYTES   = 64;
    localparam int LEN_RESET   = 24;
    // depth must stay a power of two, pointers wrap by overflow
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_TERM    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_2 = 8'h32;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_7 = 8'h37;
    localparam logic [SYM_W-1:0]  DIGIT_BASE   = 5'd26;

    typedef enum logic {
        KIND_SYMBOL,
        KIND_TERM
    } t_b32d_kind;

    typedef struct packed {
        t_b32d_kind       kind;
        logic [SYM_W-1:0] value;
    } t_b32d_item;

    typedef struct packed {
        logic             is_symbol;
        logic [SYM_W-1:0] value;
    } t_b32d_class;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } t_b32d_state;

    function automatic t_b32d_class classify(input logic [CHAR_W-1:0] c);
        t_b32d_class      res;
        logic [CHAR_W-1:0] diff;
        res  = '0;
        diff = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            diff          = c - CHAR_UPPER_A;
            res.is_symbol = 1'b1;
            res.value     = diff[SYM_W-1:0];
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            diff          = c - CHAR_LOWER_A;
            res.is_symbol = 1'b1;
            res.value     = diff[SYM_W-1:0];
        end else if (c >= CHAR_DIGIT_2 && c <= CHAR_DIGIT_7) begin
            diff          = c - CHAR_DIGIT_2;
            res.is_symbol = 1'b1;
            res.value     = diff[SYM_W-1:0] + DIGIT_BASE;
        end
        return res;
    endfunction

endpackage

[hdl/b32d_front.sv]
// input side: takes characters, drops non-alphabet ones, queues symbols and terminators
module b32d_front (
    input  logic                         i_valid,
    input  logic [b32d_pkg::CHAR_W-1:0]  i_character,
    output logic                         o_stall,
    input  logic                         i_q_full,
    output logic                         o_push,
    output b32d_pkg::t_b32d_item         o_item
);

    b32d_pkg::t_b32d_class w_class;
    logic                  w_accept;
    logic                  w_is_term;

    assign o_stall   = i_q_full;
    assign w_accept  = i_valid && !i_q_full;
    assign w_is_term = (i_character == b32d_pkg::CHAR_TERM);

    always_comb begin
        w_class = b32d_pkg::classify(i_character);
        o_push  = w_accept && (w_is_term || w_class.is_symbol);
        o_item.kind  = w_is_term ? b32d_pkg::KIND_TERM : b32d_pkg::KIND_SYMBOL;
        o_item.value = w_class.value;
    end

endmodule

[hdl/b32d_queue.sv]
// small register queue between the classifier and the decoder
module b32d_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  b32d_pkg::t_b32d_item  i_item,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_not_empty,
    output b32d_pkg::t_b32d_item  o_item
);

    b32d_pkg::t_b32d_item                r_mem [b32d_pkg::QUEUE_DEPTH];
    logic [b32d_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [b32d_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [b32d_pkg::QUEUE_CNT_W-1:0]    r_count, n_count;

    assign o_full      = (r_count == b32d_pkg::QUEUE_CNT_W'(b32d_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + b32d_pkg::QUEUE_PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + b32d_pkg::QUEUE_PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + b32d_pkg::QUEUE_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - b32d_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hdl/b32d_back.sv]
// decode side: packs symbols into bytes, pads on terminator, holds the length register
module b32d_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [b32d_pkg::LEN_W-1:0]    i_cfg_output_length,
    input  logic                          i_q_not_empty,
    input  b32d_pkg::t_b32d_item          i_q_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [b32d_pkg::BYTE_W-1:0]   o_data_byte,
    output logic                          o_last_byte
);

    b32d_pkg::t_b32d_state               r_state, n_state;
    logic [b32d_pkg::LEN_W-1:0]          r_output_length;
    logic [b32d_pkg::POS_W-1:0]          r_bit_pos, n_bit_pos;
    logic [b32d_pkg::LEN_W-1:0]          r_bytes_done, n_bytes_done;
    logic [b32d_pkg::BYTE_W-1:0]         r_partial, n_partial;
    logic                                r_out_valid, n_out_valid;
    logic [b32d_pkg::BYTE_W-1:0]         r_out_byte, n_out_byte;
    logic                                r_out_last, n_out_last;

    logic [b32d_pkg::LEN_W-1:0]                 w_len;
    logic                                       w_out_free;
    logic                                       w_full;
    logic [b32d_pkg::LEN_W-1:0]                 w_done_inc;
    logic                                       w_hit_len;
    logic [b32d_pkg::POS_W:0]                   w_pos_sum;
    logic [b32d_pkg::POS_W:0]                   w_shift;
    logic [b32d_pkg::BYTE_W+b32d_pkg::SYM_W-1:0] w_window;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_data_byte = r_out_byte;
    assign o_last_byte = r_out_last;

    always_comb begin
        if (r_output_length == '0) begin
            w_len = b32d_pkg::LEN_W'(1);
        end else if (r_output_length > b32d_pkg::LEN_W'(b32d_pkg::MAX_BYTES)) begin
            w_len = b32d_pkg::LEN_W'(b32d_pkg::MAX_BYTES);
        end else begin
            w_len = r_output_length;
        end
    end

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_full     = (r_bytes_done >= w_len);
    assign w_done_inc = r_bytes_done + b32d_pkg::LEN_W'(1);
    assign w_hit_len  = (w_done_inc == w_len);

    // accumulator on top of a 13-bit window, new symbol lands just below the filled bits
    assign w_pos_sum = {1'b0, r_bit_pos} + (b32d_pkg::POS_W+1)'(b32d_pkg::SYM_W);
    assign w_shift   = (b32d_pkg::POS_W+1)'(b32d_pkg::BYTE_W) - {1'b0, r_bit_pos};
    assign w_window  = {r_partial, b32d_pkg::SYM_W'(0)}
                     | ((b32d_pkg::BYTE_W+b32d_pkg::SYM_W)'(i_q_item.value) << w_shift);

    always_comb begin
        n_state      = r_state;
        n_bit_pos    = r_bit_pos;
        n_bytes_done = r_bytes_done;
        n_partial    = r_partial;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        if (w_out_free) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            b32d_pkg::ST_RUN: begin
                if (w_out_free && i_q_not_empty) begin
                    o_pop = 1'b1;
                    if (i_q_item.kind == b32d_pkg::KIND_TERM) begin
                        n_bit_pos = '0;
                        n_partial = '0;
                        if (!w_full) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = r_partial;
                            n_out_last  = w_hit_len;
                            if (w_hit_len) begin
                                n_bytes_done = '0;
                            end else begin
                                n_bytes_done = w_done_inc;
                                n_state      = b32d_pkg::ST_FLUSH;
                            end
                        end else begin
                            n_bytes_done = '0;
                        end
                    end else if (!w_full) begin
                        if (w_pos_sum[b32d_pkg::POS_W]) begin
                            n_out_valid  = 1'b1;
                            n_out_byte   = w_window[b32d_pkg::BYTE_W+b32d_pkg::SYM_W-1:
                                                    b32d_pkg::SYM_W];
                            n_out_last   = w_hit_len;
                            n_bytes_done = w_done_inc;
                            n_partial    = {w_window[b32d_pkg::SYM_W-1:0],
                                            (b32d_pkg::BYTE_W-b32d_pkg::SYM_W)'(0)};
                        end else begin
                            n_partial = w_window[b32d_pkg::BYTE_W+b32d_pkg::SYM_W-1:
                                                 b32d_pkg::SYM_W];
                        end
                        n_bit_pos = w_pos_sum[b32d_pkg::POS_W-1:0];
                    end
                end
            end
            b32d_pkg::ST_FLUSH: begin
                // zero padding, one beat per cycle while the output is not stalled
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = '0;
                    n_out_last  = w_hit_len;
                    if (w_hit_len) begin
                        n_bytes_done = '0;
                        n_state      = b32d_pkg::ST_RUN;
                    end else begin
                        n_bytes_done = w_done_inc;
                    end
                end
            end
            default: begin
                n_state = b32d_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= b32d_pkg::ST_RUN;
            r_output_length <= b32d_pkg::LEN_W'(b32d_pkg::LEN_RESET);
            r_bit_pos       <= '0;
            r_bytes_done    <= '0;
            r_partial       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_bit_pos    <= n_bit_pos;
            r_bytes_done <= n_bytes_done;
            r_partial    <= n_partial;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_output_length <= i_cfg_output_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule

[hdl/base32_stream_decoder.sv]
// base32 decoder top level: classifier, queue and byte packer
// a byte passes through the queue register and then the output register after the character that completes it
// throughput: one character per cycle while the output is not stalled and no flush runs
// a terminator emits the partial byte, then zero bytes for every byte still missing from the buffer, up to 64
// the queue holds 4 beats, so the input stalls only when it fills behind a flush or stall
// reset (synchronous, active low) clears the queue, the packer and sets the length to 24
module base32_stream_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [b32d_pkg::CHAR_W-1:0]   i_character,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [b32d_pkg::BYTE_W-1:0]   o_data_byte,
    output logic                          o_last_byte,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [b32d_pkg::LEN_W-1:0]    i_cfg_output_length
);

    b32d_pkg::t_b32d_item w_push_item;
    b32d_pkg::t_b32d_item w_head_item;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_full;
    logic                 w_not_empty;

    b32d_front u_front (
        .i_valid     (i_valid),
        .i_character (i_character),
        .o_stall     (o_stall),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    b32d_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_item      (w_push_item),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_item      (w_head_item)
    );

    b32d_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_output_length (i_cfg_output_length),
        .i_q_not_empty       (w_not_empty),
        .i_q_item            (w_head_item),
        .o_pop               (w_pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_data_byte         (o_data_byte),
        .o_last_byte         (o_last_byte)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_not_empty)
        else $error("pop from empty queue");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("push into full queue");

    a_term_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_character == b32d_pkg::CHAR_TERM) |->
            (w_push && w_push_item.kind == b32d_pkg::KIND_TERM))
        else $error("accepted terminator not queued");

endmodule

[bench/base32_stream_decoder_tb.sv]
// self-checking testbench for the streaming base32 decoder
`timescale 1ns / 1ps

module base32_stream_decoder_tb;

    localparam int WATCHDOG  = 2000;
    localparam int HOLD_LEN  = 60;
    localparam int SETTLE    = 16;
    localparam int N_ITEMS   = 280;

    typedef struct {
        logic [b32d_pkg::BYTE_W-1:0] data;
        logic                        last;
    } t_byte_beat;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [b32d_pkg::CHAR_W-1:0]   i_character = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [b32d_pkg::BYTE_W-1:0]   o_data_byte;
    logic                          o_last_byte;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [b32d_pkg::LEN_W-1:0]    i_cfg_output_length = '0;

    base32_stream_decoder u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_character         (i_character),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_data_byte         (o_data_byte),
        .o_last_byte         (o_last_byte),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_output_length (i_cfg_output_length)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // characters waiting to be sent and decoded bytes still due
    logic [b32d_pkg::CHAR_W-1:0] char_q[$];
    t_byte_beat                  decoded_q[$];

    // decoder shadow state
    logic [b32d_pkg::LEN_W-1:0]  len_cfg = b32d_pkg::LEN_W'(b32d_pkg::LEN_RESET);
    int                bit_pos = 0;
    int                bytes_out = 0;
    int                acc_byte = 0;

    int  n_errors = 0;
    int  n_items = 0;
    int  idle_cycles = 0;
    bit  in_taken = 1'b0;
    int  stall_pct = 0;
    int  gap_max = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;

    function automatic int buffer_len(input logic [b32d_pkg::LEN_W-1:0] len);
        int n;
        n = int'(len);
        if (n == 0) n = 1;
        if (n > b32d_pkg::MAX_BYTES) n = b32d_pkg::MAX_BYTES;
        return n;
    endfunction

    task automatic emit_byte(input int b, input int len);
        t_byte_beat e;
        bytes_out  = (bytes_out + 1) & 8'h7f;
        e.data     = b[b32d_pkg::BYTE_W-1:0];
        e.last     = (bytes_out == len);
        decoded_q  = {decoded_q, e};
    endtask

    // advance the shadow decoder by one accepted character
    task automatic decode_char(input logic [b32d_pkg::CHAR_W-1:0] c);
        int len, v, np;
        len = buffer_len(len_cfg);
        if (c == b32d_pkg::CHAR_TERM) begin
            if (bytes_out < len) begin
                emit_byte(acc_byte, len);
                while (bytes_out < len) emit_byte(0, len);
            end
            bit_pos   = 0;
            bytes_out = 0;
            acc_byte  = 0;
            return;
        end
        if (bytes_out >= len) return;
        if (c >= b32d_pkg::CHAR_UPPER_A && c <= b32d_pkg::CHAR_UPPER_Z)
            v = c - b32d_pkg::CHAR_UPPER_A;
        else if (c >= b32d_pkg::CHAR_LOWER_A && c <= b32d_pkg::CHAR_LOWER_Z)
            v = c - b32d_pkg::CHAR_LOWER_A;
        else if (c >= b32d_pkg::CHAR_DIGIT_2 && c <= b32d_pkg::CHAR_DIGIT_7)
            v = c - b32d_pkg::CHAR_DIGIT_2 + 26;
        else return;
        if (bit_pos <= 3) begin
            np = bit_pos + 5;
            if (np == 8) begin
                emit_byte(acc_byte | v, len);
                acc_byte = 0;
                bit_pos  = 0;
            end else begin
                acc_byte = (acc_byte | (v << (8 - np))) & 8'hff;
                bit_pos  = np;
            end
        end else begin
            np = bit_pos - 3;
            emit_byte(acc_byte | (v >> np), len);
            acc_byte = (v << (8 - np)) & 8'hff;
            bit_pos  = np;
        end
    endtask

    // checks, shadow updates and watchdog, all on the rising edge
    always @(posedge i_clk) begin : mon
        t_byte_beat want;
        bit         out_taken, cfg_taken;
        if (i_rst_n) begin
            in_taken  = i_valid && !o_stall;
            out_taken = o_valid && !i_stall;
            cfg_taken = i_cfg_valid && o_cfg_ready;
            if (cfg_taken) len_cfg = i_cfg_output_length;
            if (in_taken) begin
                decode_char(i_character);
                void'(char_q.pop_front());
            end
            if (out_taken) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got data %02h last %0b",
                             $time, o_data_byte, o_last_byte);
                    n_errors++;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_data_byte !== want.data) begin
                        $display("%0t: data_byte mismatch, expected %02h, got %02h",
                                 $time, want.data, o_data_byte);
                        n_errors++;
                    end
                    if (o_last_byte !== want.last) begin
                        $display("%0t: last_byte mismatch, expected %0b, got %0b",
                                 $time, want.last, o_last_byte);
                        n_errors++;
                    end
                end
            end
            if (in_taken || out_taken || cfg_taken) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG);
                $display("base32_stream_decoder_tb: FAIL");
                $finish;
            end
        end
    end

    // sender: bursts with random gaps, payload held while stalled
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            i_valid <= 1'b1;
        end else if (gap_left > 0) begin
            i_valid <= 1'b0;
            gap_left--;
        end else if (char_q.size() > 0) begin
            i_valid     <= 1'b1;
            i_character <= char_q[0];
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 12);
                gap_left   = $urandom_range(0, gap_max);
            end else begin
                burst_left--;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_LEN;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic set_len(input logic [b32d_pkg::LEN_W-1:0] len);
        @(negedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_output_length <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every character is in and every byte is out, then let the block settle
    task automatic drain();
        while (char_q.size() > 0 || decoded_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send(input logic [b32d_pkg::CHAR_W-1:0] c);
        char_q = {char_q, c};
        n_items++;
    endtask

    function automatic logic [b32d_pkg::CHAR_W-1:0] sym_char(input int v);
        if (v >= 26) return b32d_pkg::CHAR_W'(b32d_pkg::CHAR_DIGIT_2 + v - 26);
        return b32d_pkg::CHAR_W'(($urandom_range(0, 1) ? b32d_pkg::CHAR_LOWER_A
                                                        : b32d_pkg::CHAR_UPPER_A) + v);
    endfunction

    task automatic random_phase();
        int pick, eff, n_str, k;
        logic [b32d_pkg::LEN_W-1:0] len;
        pick = $urandom_range(0, 9);
        case (pick)
            0: len = '0;
            1: len = 7'd1;
            2: len = b32d_pkg::LEN_W'(b32d_pkg::MAX_BYTES);
            3: len = b32d_pkg::LEN_W'($urandom_range(b32d_pkg::MAX_BYTES + 1, 127));
            default: len = b32d_pkg::LEN_W'($urandom_range(1, 12));
        endcase
        set_len(len);
        eff = buffer_len(len);
        case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 25;
            default: stall_pct = 60;
        endcase
        case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 3;
            default: gap_max = 8;
        endcase
        n_str = $urandom_range(1, 3);
        for (int s = 0; s < n_str; s++) begin
            k = $urandom_range(0, (eff * 8) / 5 + 2);
            if (k > N_ITEMS - n_items) k = N_ITEMS - n_items;
            for (int j = 0; j < k; j++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send(b32d_pkg::CHAR_W'($urandom_range(1, 255)));
                end else begin
                    send(sym_char($urandom_range(0, 31)));
                end
            end
            // a string left open carries over into the next length setting
            if (s < n_str - 1 || $urandom_range(0, 4) != 0) begin
                send(b32d_pkg::CHAR_TERM);
            end
        end
        if ($urandom_range(0, 7) == 0) hold_req = 1'b1;
        drain();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset length: terminator first, then range edges of the character classes
        send(b32d_pkg::CHAR_TERM);
        send(b32d_pkg::CHAR_UPPER_A);
        send(b32d_pkg::CHAR_UPPER_Z);
        send(b32d_pkg::CHAR_LOWER_A);
        send(b32d_pkg::CHAR_LOWER_Z);
        send(b32d_pkg::CHAR_DIGIT_2);
        send(b32d_pkg::CHAR_DIGIT_7);
        send(b32d_pkg::CHAR_W'(b32d_pkg::CHAR_UPPER_A - 1));
        send(b32d_pkg::CHAR_W'(b32d_pkg::CHAR_UPPER_Z + 1));
        send(b32d_pkg::CHAR_W'(b32d_pkg::CHAR_LOWER_A - 1));
        send(b32d_pkg::CHAR_W'(b32d_pkg::CHAR_LOWER_Z + 1));
        send(b32d_pkg::CHAR_W'(b32d_pkg::CHAR_DIGIT_2 - 1));
        send(b32d_pkg::CHAR_W'(b32d_pkg::CHAR_DIGIT_7 + 1));
        send(8'hff);
        send(8'h80);
        send(b32d_pkg::CHAR_TERM);
        drain();

        // zero length acts as one byte; overflow characters ignored
        set_len('0);
        for (int j = 0; j < 8; j++) send(b32d_pkg::CHAR_DIGIT_7);
        send(b32d_pkg::CHAR_TERM);
        send(b32d_pkg::CHAR_TERM);
        drain();

        // length beyond the limit, then shrunk below the bytes already out
        set_len(7'd127);
        for (int j = 0; j < 10; j++) send(sym_char(j * 3));
        drain();
        set_len(7'd3);
        send(b32d_pkg::CHAR_UPPER_A);
        send(b32d_pkg::CHAR_TERM);
        drain();

        // long receiver hold-off while the sender keeps going, then a shrunk length mid-string
        set_len(7'd65);
        stall_pct = 20;
        for (int j = 0; j < 30; j++) send(sym_char($urandom_range(0, 31)));
        hold_req = 1'b1;
        drain();
        set_len(7'd40);
        send(b32d_pkg::CHAR_TERM);
        drain();

        while (n_items < N_ITEMS) random_phase();

        drain();
        if (n_errors == 0) begin
            $display("base32_stream_decoder_tb: PASS");
        end else begin
            $display("base32_stream_decoder_tb: FAIL");
        end
        $finish;
    end

endmodule
